// ===== rtl/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc_pkg
// Types and constants shared by the sphere frustum cull block and its users.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int COORD_W = 32;
    localparam int RADIUS_W = 31;
    localparam int COEF_W = 16;
    localparam int RATIO_W = 16;
    localparam int ROT_W = 48;
    localparam int WIDE_REG_W = 64;
    localparam int NARROW_REG_W = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_INDEX_W = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_COL_X = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_COL_Y = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_COL_Z = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TRANS_XY = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TRANS_Z = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_NEAR_FAR = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SIDE_RATIOS = 3'd6;

    // Reset values
    localparam logic [ROT_W-1:0] ROT_COL_X_RST = 48'h0000_0000_4000;
    localparam logic [ROT_W-1:0] ROT_COL_Y_RST = 48'h0000_4000_0000;
    localparam logic [ROT_W-1:0] ROT_COL_Z_RST = 48'h4000_0000_0000;
    localparam logic [NARROW_REG_W-1:0] SIDE_RATIOS_RST = 32'h1000_1000;

    // Cull causes
    localparam logic [1:0] CAUSE_NONE = 2'd0;
    localparam logic [1:0] CAUSE_NEAR_FAR = 2'd1;
    localparam logic [1:0] CAUSE_SIDES = 2'd2;
    localparam logic [1:0] CAUSE_TOP_BOTTOM = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [RADIUS_W-1:0]       radius;
        logic                      test_near_far;
        logic                      test_sides;
        logic                      test_top_bottom;
    } sphere_t;

    typedef struct packed {
        logic       culled;
        logic [1:0] cause;
    } result_t;

endpackage

// ===== rtl/sphere_frustum_cull.sv =====
// ----------------------------------------------------------------------------
// sphere_frustum_cull
// Culls a bounding sphere against a view frustum. One sphere is taken per
// clock: busy is always low, so any cycle with start high is a transfer. The
// result of a sphere is shown for one cycle, marked by done; the receiver
// cannot hold it off. The pipeline has five register stages: rotation
// products, product sums, shift, translate
// and saturate, side-limit products with the near/far test, and the side
// compares with the cause select. Configuration writes take effect at once
// and belong in idle periods only.
// ----------------------------------------------------------------------------
module sphere_frustum_cull (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  sfc_pkg::sphere_t                    sphere,
    output logic                                done,
    output sfc_pkg::result_t                    result,
    input  logic                                wr_en,
    input  logic [sfc_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  logic [sfc_pkg::CFG_DATA_W-1:0]      wr_data
);
    import sfc_pkg::*;

    localparam int PROD_W = COEF_W + COORD_W;   // 48
    localparam int SUM_W = PROD_W + 2;          // 50
    localparam int EXT_W = SUM_W + 1;           // 51
    localparam int LIM_PROD_W = COORD_W + RATIO_W + 1;
    localparam int CMP_W = COORD_W + 2;

    // Configuration registers
    logic [ROT_W-1:0]        rot_col_reg [3];
    logic [WIDE_REG_W-1:0]   trans_xy_reg;
    logic [NARROW_REG_W-1:0] trans_z_reg;
    logic [WIDE_REG_W-1:0]   clip_near_far_reg;
    logic [NARROW_REG_W-1:0] side_ratios_reg;

    // Stage valid bits
    logic [4:0] valid_reg;

    // Stage 1
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic [RADIUS_W-1:0]      s1_radius_reg;
    logic [2:0]               s1_tests_reg;
    // Stage 2
    logic signed [SUM_W-1:0]  sum_reg [3];
    logic [RADIUS_W-1:0]      s2_radius_reg;
    logic [2:0]               s2_tests_reg;
    // Stage 3
    logic signed [COORD_W-1:0] cam_reg [3];
    logic signed [COORD_W-1:0] cam_next [3];
    logic [RADIUS_W-1:0]      s3_radius_reg;
    logic [2:0]               s3_tests_reg;
    // Stage 4
    logic signed [LIM_PROD_W-1:0] lim_prod_reg [2];
    logic signed [COORD_W-1:0]    s4_x_reg;
    logic signed [COORD_W-1:0]    s4_y_reg;
    logic [RADIUS_W-1:0]          s4_radius_reg;
    logic [1:0]                   s4_tests_reg;
    logic                         nf_hit_reg;
    logic                         nf_hit_next;
    // Stage 5
    result_t                      result_reg;
    result_t                      result_next;

    logic signed [CMP_W-1:0]  r_ext3;
    logic signed [CMP_W-1:0]  z_ext;
    logic signed [CMP_W-1:0]  r_ext5;
    logic signed [CMP_W-1:0]  x_ext;
    logic signed [CMP_W-1:0]  y_ext;
    logic signed [COORD_W-1:0] lim [2];
    logic signed [CMP_W-1:0]  lim_ext [2];
    logic                     side_hit;
    logic                     tb_hit;
    logic                     accept;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [EXT_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (!v[EXT_W-1] && (|v[EXT_W-2:COORD_W-1]))
        begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (v[EXT_W-1] && !(&v[EXT_W-2:COORD_W-1]))
        begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    assign busy = 1'b0;
    assign accept = start && !busy;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_col_reg[0]    <= ROT_COL_X_RST;
            rot_col_reg[1]    <= ROT_COL_Y_RST;
            rot_col_reg[2]    <= ROT_COL_Z_RST;
            trans_xy_reg      <= '0;
            trans_z_reg       <= '0;
            clip_near_far_reg <= '0;
            side_ratios_reg   <= SIDE_RATIOS_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ROT_COL_X:     rot_col_reg[0] <= wr_data[ROT_W-1:0];
                REG_ROT_COL_Y:     rot_col_reg[1] <= wr_data[ROT_W-1:0];
                REG_ROT_COL_Z:     rot_col_reg[2] <= wr_data[ROT_W-1:0];
                REG_TRANS_XY:      trans_xy_reg <= wr_data;
                REG_TRANS_Z:       trans_z_reg <= wr_data[NARROW_REG_W-1:0];
                REG_CLIP_NEAR_FAR: clip_near_far_reg <= wr_data;
                REG_SIDE_RATIOS:   side_ratios_reg <= wr_data[NARROW_REG_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], accept};
        end
    end

    // Stage 1: nine coefficient by coordinate products
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod_reg[c][0] <= $signed(rot_col_reg[c][COEF_W-1:0]) * sphere.center_x;
            prod_reg[c][1] <= $signed(rot_col_reg[c][2*COEF_W-1:COEF_W]) * sphere.center_y;
            prod_reg[c][2] <= $signed(rot_col_reg[c][3*COEF_W-1:2*COEF_W]) * sphere.center_z;
        end
        s1_radius_reg <= sphere.radius;
        s1_tests_reg  <= {sphere.test_near_far, sphere.test_sides, sphere.test_top_bottom};
    end

    // Stage 2: sum the products of each camera coordinate
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum_reg[c] <= SUM_W'(prod_reg[c][0]) + SUM_W'(prod_reg[c][1])
                        + SUM_W'(prod_reg[c][2]);
        end
        s2_radius_reg <= s1_radius_reg;
        s2_tests_reg  <= s1_tests_reg;
    end

    // Stage 3: drop the Q2.14 fraction (floor), translate, saturate
    always_comb
    begin
        cam_next[0] = sat32(EXT_W'(sum_reg[0] >>> 14)
                            + EXT_W'($signed(trans_xy_reg[COORD_W-1:0])));
        cam_next[1] = sat32(EXT_W'(sum_reg[1] >>> 14)
                            + EXT_W'($signed(trans_xy_reg[2*COORD_W-1:COORD_W])));
        cam_next[2] = sat32(EXT_W'(sum_reg[2] >>> 14) + EXT_W'($signed(trans_z_reg)));
    end

    always_ff @(posedge clk)
    begin
        cam_reg       <= cam_next;
        s3_radius_reg <= s2_radius_reg;
        s3_tests_reg  <= s2_tests_reg;
    end

    // Stage 4: side-limit products and the near/far test
    assign r_ext3 = CMP_W'({1'b0, s3_radius_reg});
    assign z_ext  = CMP_W'(cam_reg[2]);

    always_comb
    begin
        nf_hit_next = s3_tests_reg[2]
            && ((z_ext - r_ext3 > CMP_W'($signed(clip_near_far_reg[2*COORD_W-1:COORD_W])))
                || (z_ext + r_ext3 < CMP_W'($signed(clip_near_far_reg[COORD_W-1:0]))));
    end

    always_ff @(posedge clk)
    begin
        lim_prod_reg[0] <= cam_reg[2] * $signed({1'b0, side_ratios_reg[RATIO_W-1:0]});
        lim_prod_reg[1] <= cam_reg[2]
                           * $signed({1'b0, side_ratios_reg[2*RATIO_W-1:RATIO_W]});
        s4_x_reg      <= cam_reg[0];
        s4_y_reg      <= cam_reg[1];
        s4_radius_reg <= s3_radius_reg;
        s4_tests_reg  <= s3_tests_reg[1:0];
        nf_hit_reg    <= nf_hit_next;
    end

    // Stage 5: side compares and cause select; near/far wins, then sides, then top/bottom
    assign r_ext5 = CMP_W'({1'b0, s4_radius_reg});
    assign x_ext  = CMP_W'(s4_x_reg);
    assign y_ext  = CMP_W'(s4_y_reg);

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            lim[k]     = sat32(EXT_W'(lim_prod_reg[k] >>> 12));
            lim_ext[k] = CMP_W'(lim[k]);
        end
        side_hit = s4_tests_reg[1]
            && ((x_ext - r_ext5 > lim_ext[0]) || (x_ext + r_ext5 < -lim_ext[0]));
        tb_hit = s4_tests_reg[0]
            && ((y_ext - r_ext5 > lim_ext[1]) || (y_ext + r_ext5 < -lim_ext[1]));
        if (nf_hit_reg)
        begin
            result_next.cause = CAUSE_NEAR_FAR;
        end
        else if (side_hit)
        begin
            result_next.cause = CAUSE_SIDES;
        end
        else if (tb_hit)
        begin
            result_next.cause = CAUSE_TOP_BOTTOM;
        end
        else
        begin
            result_next.cause = CAUSE_NONE;
        end
        result_next.culled = (result_next.cause != CAUSE_NONE);
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = valid_reg[4];
    assign result = result_reg;

    // A result strobe always traces back to a matching transfer
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 5))
        else $error("done without a matching transfer");

    // Near/far cause only when that test was enabled on the transfer
    a_nf_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.cause == CAUSE_NEAR_FAR) |-> $past(sphere.test_near_far, 5))
        else $error("near/far cause with test disabled");

    // Top/bottom cause only when that test was enabled on the transfer
    a_tb_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.cause == CAUSE_TOP_BOTTOM) |-> $past(sphere.test_top_bottom, 5))
        else $error("top/bottom cause with test disabled");

endmodule
